@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker rmbs_checker of this block.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rmbs_pkg.sv @@
// Package of the rate matching bit selection block: widths, codes and structs.
// No dependencies; every other file of the block but assert_macros.svh uses it.
`timescale 1ns / 1ps
`default_nettype none

package rmbs_pkg;

    localparam int MAX_ROWS  = 192;
    localparam int VAL_W     = 16;
    localparam int DEPTH     = 96 * MAX_ROWS;
    localparam int POS_W     = 15;
    localparam int E_W       = 20;
    localparam int DIVD_W    = 22;
    localparam int DVS_W     = 16;
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 3;
    localparam int COLS_W    = 4;
    localparam int G_W       = 7;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_START   = 2'd1,
        CMD_EMIT    = 2'd2,
        CMD_COMBINE = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ALL_NULL = 2'd1,
        ST_NO_RUN   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS   = 3'd0,
        CFG_TOTAL  = 3'd1,
        CFG_BLOCKS = 3'd2,
        CFG_NSOFT  = 3'd3,
        CFG_HARQ   = 3'd4,
        CFG_MIMO   = 3'd5,
        CFG_QM     = 3'd6,
        CFG_LAYERS = 3'd7
    } t_cfg_idx;

    // Order of the divisions done for a start item.
    typedef enum logic [2:0] {
        DS_NSOFT = 3'd0,
        DS_HARQ  = 3'd1,
        DS_CB    = 3'd2,
        DS_LAYER = 3'd3,
        DS_QM    = 3'd4,
        DS_GP    = 3'd5,
        DS_COLS  = 3'd6,
        DS_K0    = 3'd7
    } t_div_step;

    typedef struct packed {
        logic      capture;
        logic      mem_load;
        logic      div_go;
        logic      div_take;
        t_div_step dstep;
        logic      start_fin;
        logic      scan_init;
        logic      scan_step;
        logic      sel_hit;
        logic      res_err;
        t_status   err_code;
        logic      out_push;
    } t_ctl_cmd;

    typedef struct packed {
        logic div_done;
        logic run_active;
        logic is_null;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] selected_value;
        logic [POS_W-1:0]        buffer_position;
        logic                    last_of_run;
        logic                    sum_overflow;
        logic [E_W-1:0]          bits_for_block;
        logic [POS_W-1:0]        start_position;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/rmbs_if.sv @@
// Channel interfaces of the block: input items, result items, register writes.
// Depends on rmbs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rmbs_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [1:0]                                command;
    logic [rmbs_pkg::POS_W-1:0]                entry_index;
    logic signed [rmbs_pkg::VAL_W-1:0]         entry_value;
    logic                                      entry_is_null;
    logic [1:0]                                redundancy_version;
    logic [7:0]                                block_number;
    logic signed [rmbs_pkg::VAL_W-1:0]         soft_sample;
    modport source (output valid, command, entry_index, entry_value, entry_is_null,
                    redundancy_version, block_number, soft_sample, input ready);
    modport sink (input valid, command, entry_index, entry_value, entry_is_null,
                  redundancy_version, block_number, soft_sample, output ready);
endinterface

interface rmbs_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [rmbs_pkg::VAL_W-1:0] selected_value;
    logic [rmbs_pkg::POS_W-1:0]        buffer_position;
    logic                              last_of_run;
    logic                              sum_overflow;
    logic [rmbs_pkg::E_W-1:0]          bits_for_block;
    logic [rmbs_pkg::POS_W-1:0]        start_position;
    modport source (output valid, status, selected_value, buffer_position, last_of_run,
                    sum_overflow, bits_for_block, start_position, input ready);
    modport sink (input valid, status, selected_value, buffer_position, last_of_run,
                  sum_overflow, bits_for_block, start_position, output ready);
endinterface

interface rmbs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rmbs_pkg::CFG_IDX_W-1:0]    addr;
    logic [rmbs_pkg::CFG_W-1:0]        data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ hdl/rmbs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the start computations.
// Depends on rmbs_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module rmbs_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_go,
    input  wire [rmbs_pkg::DIVD_W-1:0]     i_dividend,
    input  wire [rmbs_pkg::DVS_W-1:0]      i_divisor,
    output logic                           o_done,
    output logic [rmbs_pkg::DIVD_W-1:0]    o_quo,
    output logic [rmbs_pkg::DVS_W-1:0]     o_rem
);
    import rmbs_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;
    logic              fits;

    always_comb begin
        shifted = {r_rem, r_quo[DIVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        fits    = shifted >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], fits};
            r_rem <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ hdl/rmbs_ctrl.sv @@
// Controller of the bit selection block: sequences loads, starts and selections.
// Depends on rmbs_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rmbs_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire [1:0]            i_in_command,
    output logic                 o_in_ready,
    input  rmbs_pkg::t_dp_stat   i_stat,
    output rmbs_pkg::t_ctl_cmd   o_cmd
);
    import rmbs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_DWAIT = 9'b000001000,
        S_SRES  = 9'b000010000,
        S_SEL   = 9'b000100000,
        S_RD    = 9'b001000000,
        S_CHK   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state    r_state, n_state;
    t_div_step r_dstep, n_dstep;

    always_comb begin
        n_state    = r_state;
        n_dstep    = r_dstep;
        o_cmd      = '0;
        o_cmd.dstep    = r_dstep;
        o_cmd.err_code = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (t_cmd_code'(i_in_command))
                        CMD_LOAD: n_state = S_LOAD;
                        CMD_START: begin
                            n_state = S_DIV;
                            n_dstep = DS_NSOFT;
                        end
                        default: n_state = S_SEL;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.mem_load = 1'b1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    if (r_dstep == DS_K0) begin
                        n_state = S_SRES;
                    end else begin
                        n_dstep = t_div_step'(r_dstep + 3'd1);
                        n_state = S_DIV;
                    end
                end
            end
            S_SRES: begin
                o_cmd.start_fin = 1'b1;
                n_state = S_OUT;
            end
            S_SEL: begin
                if (!i_stat.run_active) begin
                    o_cmd.res_err  = 1'b1;
                    o_cmd.err_code = ST_NO_RUN;
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (!i_stat.is_null) begin
                    o_cmd.sel_hit = 1'b1;
                    n_state = S_OUT;
                end else if (i_stat.scan_last) begin
                    o_cmd.res_err  = 1'b1;
                    o_cmd.err_code = ST_ALL_NULL;
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dstep <= DS_NSOFT;
        end else begin
            r_state <= n_state;
            r_dstep <= n_dstep;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rmbs_dp.sv @@
// Datapath of the bit selection block: registers, entry memory, start math.
// Depends on rmbs_pkg and on the divider rmbs_div.
`timescale 1ns / 1ps
`default_nettype none

module rmbs_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  rmbs_pkg::t_ctl_cmd                 i_cmd,
    output rmbs_pkg::t_dp_stat                 o_stat,
    input  wire [1:0]                          i_command,
    input  wire [rmbs_pkg::POS_W-1:0]          i_entry_index,
    input  wire signed [rmbs_pkg::VAL_W-1:0]   i_entry_value,
    input  wire                                i_entry_is_null,
    input  wire [1:0]                          i_redundancy_version,
    input  wire [7:0]                          i_block_number,
    input  wire signed [rmbs_pkg::VAL_W-1:0]   i_soft_sample,
    input  wire                                i_cfg_we,
    input  wire [rmbs_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire [rmbs_pkg::CFG_W-1:0]          i_cfg_data,
    output rmbs_pkg::t_result                  o_res,
    output logic                               o_out_valid,
    input  wire                                i_out_ready
);
    import rmbs_pkg::*;

    // Configuration registers.
    logic [7:0]  r_rows;
    logic [19:0] r_total;
    logic [7:0]  r_blocks;
    logic [21:0] r_nsoft;
    logic [3:0]  r_harq;
    logic [1:0]  r_mimo;
    logic [3:0]  r_qm;
    logic [2:0]  r_layers;

    // Captured item.
    logic [1:0]              r_command;
    logic [POS_W-1:0]        r_idx;
    logic [VAL_W-1:0]        r_val;
    logic                    r_null;
    logic [1:0]              r_rv;
    logic [7:0]              r_blk;
    logic signed [VAL_W-1:0] r_sample;

    // Start computation.
    logic [DIVD_W-1:0] r_acc;
    logic [POS_W-1:0]  r_ncb;
    logic [G_W-1:0]    r_g;
    logic [E_W-1:0]    r_e;
    logic [COLS_W-1:0] r_cols;
    logic [POS_W-1:0]  r_k0;

    // Run state.
    logic [POS_W-1:0] r_rdpos;
    logic [POS_W-1:0] r_circ;
    logic [E_W-1:0]   r_remain;
    logic             r_run;

    // Scan.
    logic [POS_W-1:0] r_scan_pos;
    logic [POS_W-1:0] r_scan_cnt;

    logic [VAL_W:0] mem [DEPTH];
    logic [VAL_W:0] r_rd;

    t_result r_res;
    t_result r_out;
    logic    r_ovalid;

    logic [7:0]        rtc_e;
    logic [7:0]        c_e;
    logic [3:0]        harq_e;
    logic [1:0]        km_e;
    logic [3:0]        qm_e;
    logic [2:0]        nl_e;
    logic [POS_W-1:0]  lim;
    logic [10:0]       rtc8;
    logic [DIVD_W-1:0] dvd;
    logic [DVS_W-1:0]  dvs;
    logic [DIVD_W-1:0] num;
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;
    logic [DVS_W-1:0]  div_rem;
    logic              inc;
    logic [27:0]       e_full;
    logic [POS_W-1:0]  ncb_new;
    logic signed [VAL_W:0]   sum;
    logic signed [VAL_W-1:0] v_rd;
    logic              ovf;
    logic              is_comb;
    logic [POS_W-1:0]  pos_nx;

    always_comb begin
        rtc_e  = (r_rows == 8'd0) ? 8'd1 :
                 (r_rows > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : r_rows;
        c_e    = (r_blocks == 8'd0) ? 8'd1 : r_blocks;
        harq_e = (r_harq == 4'd0) ? 4'd1 : (r_harq > 4'd8) ? 4'd8 : r_harq;
        km_e   = (r_mimo == 2'd0) ? 2'd1 : r_mimo;
        qm_e   = (r_qm == 4'd0) ? 4'd1 : r_qm;
        nl_e   = (r_layers == 3'd0) ? 3'd1 : r_layers;
        lim    = POS_W'(16'(rtc_e) * 16'd96);
        rtc8   = {rtc_e, 3'b000};
        num    = DIVD_W'(rtc_e) *
                 (DIVD_W'(r_cols) * DIVD_W'(r_rv) * DIVD_W'(2) + DIVD_W'(2));
    end

    always_comb begin
        dvd = r_acc;
        dvs = DVS_W'(c_e);
        case (i_cmd.dstep)
            DS_NSOFT: begin
                dvd = r_nsoft;
                dvs = DVS_W'(km_e);
            end
            DS_HARQ:  dvs = DVS_W'(harq_e);
            DS_CB:    dvs = DVS_W'(c_e);
            DS_LAYER: begin
                dvd = DIVD_W'(r_total);
                dvs = DVS_W'(nl_e);
            end
            DS_QM:    dvs = DVS_W'(qm_e);
            DS_GP:    dvs = DVS_W'(c_e);
            DS_COLS: begin
                dvd = DIVD_W'(r_ncb) + DIVD_W'(rtc8) - DIVD_W'(1);
                dvs = DVS_W'(rtc8);
            end
            DS_K0: begin
                dvd = num;
                dvs = DVS_W'(r_ncb);
            end
            default: dvd = r_acc;
        endcase
    end

    rmbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // The ceil branch applies when the block number reaches C minus the remainder.
    always_comb begin
        inc     = (div_rem != '0) && (9'(r_blk) >= (9'(c_e) - 9'(div_rem[7:0])));
        e_full  = 28'(r_g) * 28'(21'(div_quo[19:0]) + 21'(inc));
        ncb_new = (div_quo == '0) ? POS_W'(1) :
                  (div_quo > DIVD_W'(lim)) ? lim : div_quo[POS_W-1:0];
    end

    always_comb begin
        v_rd    = r_rd[VAL_W-1:0];
        sum     = {v_rd[VAL_W-1], v_rd} + {r_sample[VAL_W-1], r_sample};
        ovf     = sum[VAL_W] != sum[VAL_W-1];
        is_comb = t_cmd_code'(r_command) == CMD_COMBINE;
        pos_nx  = ((16'(r_scan_pos) + 16'd1) >= 16'(r_circ)) ? '0 : r_scan_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= 8'd192;
            r_total  <= 20'd1;
            r_blocks <= 8'd1;
            r_nsoft  <= 22'd1827072;
            r_harq   <= 4'd8;
            r_mimo   <= 2'd1;
            r_qm     <= 4'd2;
            r_layers <= 3'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_ROWS:   r_rows   <= i_cfg_data[7:0];
                CFG_TOTAL:  r_total  <= i_cfg_data[19:0];
                CFG_BLOCKS: r_blocks <= i_cfg_data[7:0];
                CFG_NSOFT:  r_nsoft  <= i_cfg_data[21:0];
                CFG_HARQ:   r_harq   <= i_cfg_data[3:0];
                CFG_MIMO:   r_mimo   <= i_cfg_data[1:0];
                CFG_QM:     r_qm     <= i_cfg_data[3:0];
                CFG_LAYERS: r_layers <= i_cfg_data[2:0];
                default:    r_rows   <= r_rows;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_command;
            r_idx     <= i_entry_index;
            r_val     <= i_entry_value;
            r_null    <= i_entry_is_null;
            r_rv      <= i_redundancy_version;
            r_blk     <= i_block_number;
            r_sample  <= i_soft_sample;
        end
        if (i_cmd.div_go) begin
            r_g <= G_W'(nl_e * qm_e);
        end
        if (i_cmd.div_take) begin
            case (i_cmd.dstep)
                DS_CB:   r_ncb  <= ncb_new;
                DS_GP:   r_e    <= e_full[E_W-1:0];
                DS_COLS: r_cols <= div_quo[COLS_W-1:0];
                DS_K0:   r_k0   <= div_rem[POS_W-1:0];
                default: r_acc  <= div_quo;
            endcase
        end
        if (i_cmd.scan_init) begin
            r_scan_pos <= r_rdpos;
            r_scan_cnt <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_pos <= pos_nx;
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (i_cmd.start_fin) begin
            r_res <= '{status: ST_OK, selected_value: '0, buffer_position: '0,
                       last_of_run: 1'b0, sum_overflow: 1'b0,
                       bits_for_block: r_e, start_position: r_k0};
        end else if (i_cmd.res_err) begin
            r_res <= '{status: i_cmd.err_code, default: '0};
        end else if (i_cmd.sel_hit) begin
            r_res <= '{status: ST_OK,
                       selected_value: is_comb ? sum[VAL_W-1:0] : v_rd,
                       buffer_position: r_scan_pos,
                       last_of_run: r_remain == E_W'(1),
                       sum_overflow: is_comb & ovf,
                       bits_for_block: '0, start_position: '0};
        end
        if (i_cmd.out_push) begin
            r_out <= r_res;
        end
    end

    // Entry memory: one write port (load or combine write-back), one registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_load && (32'(r_idx) < DEPTH)) begin
            mem[r_idx] <= {r_null, r_val};
        end else if (i_cmd.sel_hit && is_comb) begin
            mem[r_scan_pos] <= {1'b0, sum[VAL_W-1:0]};
        end
        r_rd <= mem[r_scan_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdpos  <= '0;
            r_circ   <= '0;
            r_remain <= '0;
            r_run    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.start_fin) begin
                r_circ   <= r_ncb;
                r_rdpos  <= r_k0;
                r_remain <= r_e;
                r_run    <= r_e != '0;
            end else if (i_cmd.sel_hit) begin
                r_remain <= r_remain - 1'b1;
                r_rdpos  <= pos_nx;
                if (r_remain == E_W'(1)) begin
                    r_run <= 1'b0;
                end
            end
            if (i_cmd.out_push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.div_done   = div_done;
        o_stat.run_active = r_run;
        o_stat.is_null    = r_rd[VAL_W];
        o_stat.scan_last  = (16'(r_scan_cnt) + 16'd1) == 16'(r_circ);
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    assign o_res       = r_out;
    assign o_out_valid = r_ovalid;

endmodule

`default_nettype wire

@@ hdl/turbo_rate_match_bit_select_top.sv @@
// Top level of the turbo rate matching bit selection block.
// Depends on rmbs_pkg, rmbs_if, rmbs_ctrl, rmbs_dp and rmbs_div.
`timescale 1ns / 1ps
`default_nettype none

// One item is taken at a time. A load goes through the load state back to idle. A start
// item runs eight divisions on one shared restoring divider of 22 quotient bits, one
// after the other, before its result is formed. An emit or combine item reads the
// entries from its run position on, one at a time through the registered read of the
// entry memory, skipping null entries; a buffer with only null entries is read over
// every entry of Ncb. A finished result waits in the output register while the next
// item is taken. Register writes are always accepted.

module turbo_rate_match_bit_select_top (
    input  wire      i_clk,
    input  wire      i_rst_n,
    rmbs_in_if.sink  i_in,
    rmbs_out_if.source o_out,
    rmbs_cfg_if.sink i_cfg
);
    import rmbs_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;
    t_result  res;
    logic     in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    rmbs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .o_in_ready   (in_ready),
        .i_stat       (dp_stat),
        .o_cmd        (ctl_cmd)
    );

    rmbs_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (ctl_cmd),
        .o_stat               (dp_stat),
        .i_command            (i_in.command),
        .i_entry_index        (i_in.entry_index),
        .i_entry_value        (i_in.entry_value),
        .i_entry_is_null      (i_in.entry_is_null),
        .i_redundancy_version (i_in.redundancy_version),
        .i_block_number       (i_in.block_number),
        .i_soft_sample        (i_in.soft_sample),
        .i_cfg_we             (i_cfg.valid),
        .i_cfg_addr           (i_cfg.addr),
        .i_cfg_data           (i_cfg.data),
        .o_res                (res),
        .o_out_valid          (o_out.valid),
        .i_out_ready          (o_out.ready)
    );

    assign o_out.status          = res.status;
    assign o_out.selected_value  = res.selected_value;
    assign o_out.buffer_position = res.buffer_position;
    assign o_out.last_of_run     = res.last_of_run;
    assign o_out.sum_overflow    = res.sum_overflow;
    assign o_out.bits_for_block  = res.bits_for_block;
    assign o_out.start_position  = res.start_position;

endmodule

`default_nettype wire

@@ hdl/rmbs_checker.sv @@
// Port-level checker of the bit selection block, bound to the top level.
// Depends on rmbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rmbs_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_out_valid,
    input wire                         i_out_ready,
    input wire [1:0]                   i_status,
    input wire [rmbs_pkg::VAL_W-1:0]   i_value,
    input wire [rmbs_pkg::POS_W-1:0]   i_pos,
    input wire                         i_last,
    input wire                         i_ovf,
    input wire [rmbs_pkg::E_W-1:0]     i_e,
    input wire [rmbs_pkg::POS_W-1:0]   i_k0
);
    import rmbs_pkg::*;

    `ASSERT_NEXT(a_valid_holds, i_out_valid && !i_out_ready, i_out_valid, "result item dropped")
    `ASSERT_IMPLY(a_status_code, i_out_valid, i_status == ST_OK || i_status == ST_ALL_NULL || i_status == ST_NO_RUN, "bad status code")
    `ASSERT_IMPLY(a_err_zero, i_out_valid && i_status != ST_OK, i_value == '0 && i_pos == '0 && !i_last && !i_ovf && i_e == '0 && i_k0 == '0, "error item carries data")
    `ASSERT_IMPLY(a_pos_range, i_out_valid, 32'(i_pos) < DEPTH && 32'(i_k0) < DEPTH, "position beyond buffer")

endmodule

bind turbo_rate_match_bit_select_top rmbs_checker u_rmbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_value     (o_out.selected_value),
    .i_pos       (o_out.buffer_position),
    .i_last      (o_out.last_of_run),
    .i_ovf       (o_out.sum_overflow),
    .i_e         (o_out.bits_for_block),
    .i_k0        (o_out.start_position)
);

`default_nettype wire

@@ tb/sv/turbo_rate_match_bit_select_top_test.sv @@
// Testbench of turbo_rate_match_bit_select_top: random and directed items on the
// input channel, register writes between phases, results checked against a predictor.
// Depends on rmbs_pkg, rmbs_if and the block's RTL.
`timescale 1ns / 1ps

module turbo_rate_match_bit_select_top_test;
    import rmbs_pkg::*;

    localparam int IDLE_LIMIT = 100000;
    localparam int SETTLE = 260;
    // Entries loaded up front; every register set that the test writes keeps Ncb at or below this.
    localparam int FILL = 256;

    typedef struct {
        t_cmd_code   cmd;
        logic [14:0] index;
        logic [15:0] value;
        logic        is_null;
        logic [1:0]  rv;
        logic [7:0]  block;
        logic [15:0] sample;
    } t_sel_item;

    // Predicts the block's results and holds those not yet returned.
    class bit_select_scoreboard;
        logic [15:0] store [DEPTH];
        bit          nulls [DEPTH];
        int unsigned regs [8];
        int unsigned read_pos, ncb_len, left;
        bit          active;
        t_result     pending_q [$];
        int          errors;

        function new();
            regs = '{192, 1, 1, 1827072, 8, 1, 2, 1};
            read_pos = 0;
            ncb_len = 0;
            left = 0;
            active = 0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ROWS:   regs[idx] = data[7:0];
                CFG_TOTAL:  regs[idx] = data[19:0];
                CFG_BLOCKS: regs[idx] = data[7:0];
                CFG_NSOFT:  regs[idx] = data[21:0];
                CFG_HARQ:   regs[idx] = data[3:0];
                CFG_MIMO:   regs[idx] = data[1:0];
                CFG_QM:     regs[idx] = data[3:0];
                default:    regs[idx] = data[2:0];
            endcase
        endfunction

        function int unsigned one_min(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        function void start_run(logic [1:0] rv, logic [7:0] blk, ref t_result res);
            int unsigned rtc, c, harq, qm, nl, nir, ncb, gp, gpmod, e, cols, k0;
            rtc = one_min(regs[CFG_ROWS]);
            if (rtc > MAX_ROWS) rtc = MAX_ROWS;
            c = one_min(regs[CFG_BLOCKS]);
            harq = one_min(regs[CFG_HARQ]);
            if (harq > 8) harq = 8;
            qm = one_min(regs[CFG_QM]);
            nl = one_min(regs[CFG_LAYERS]);
            nir = regs[CFG_NSOFT] / one_min(regs[CFG_MIMO]) / harq;
            ncb = nir / c;
            if (ncb > 96 * rtc) ncb = 96 * rtc;
            ncb = one_min(ncb);
            gp = regs[CFG_TOTAL] / nl / qm;
            gpmod = gp % c;
            if (blk < c - gpmod) e = nl * qm * (gp / c);
            else e = nl * qm * (gp / c + ((gpmod != 0) ? 1 : 0));
            cols = (ncb + 8 * rtc - 1) / (8 * rtc);
            k0 = (rtc * (2 * cols * rv + 2)) % ncb;
            ncb_len = ncb;
            read_pos = k0;
            left = e & 32'hFFFFF;
            active = (left != 0);
            res.bits_for_block = left[19:0];
            res.start_position = k0[14:0];
        endfunction

        function void select_entry(bit combine, logic [15:0] smp, ref t_result res);
            int unsigned pos;
            int          sum;
            bit          found;
            logic [15:0] wrapped;
            if (!active) begin
                res.status = ST_NO_RUN;
                return;
            end
            pos = read_pos;
            found = 0;
            for (int unsigned i = 0; i < ncb_len; i++) begin
                if (pos < DEPTH && !nulls[pos]) begin
                    found = 1;
                    break;
                end
                pos++;
                if (pos >= ncb_len) pos = 0;
            end
            if (!found) begin
                res.status = ST_ALL_NULL;
                return;
            end
            if (combine) begin
                sum = int'($signed(store[pos])) + int'($signed(smp));
                wrapped = sum[15:0];
                res.sum_overflow = (int'($signed(wrapped)) != sum);
                store[pos] = wrapped;
            end
            res.selected_value = store[pos];
            res.buffer_position = pos[14:0];
            res.last_of_run = (left == 1);
            left--;
            if (left == 0) active = 0;
            pos++;
            read_pos = (pos >= ncb_len) ? 0 : pos;
        endfunction

        function void note_item(t_sel_item it);
            t_result res;
            if (it.cmd == CMD_LOAD) begin
                if (it.index < DEPTH) begin
                    store[it.index] = it.value;
                    nulls[it.index] = it.is_null;
                end
                return;
            end
            res = '0;
            if (it.cmd == CMD_START) start_run(it.rv, it.block, res);
            else select_entry(it.cmd == CMD_COMBINE, it.sample, res);
            pending_q.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                $error("result with no item waiting for it");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.selected_value !== want.selected_value) begin
                $error("selected_value: expected %0d, got %0d",
                       want.selected_value, got.selected_value);
                errors++;
            end
            if (got.buffer_position !== want.buffer_position) begin
                $error("buffer_position: expected %0d, got %0d",
                       want.buffer_position, got.buffer_position);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
                errors++;
            end
            if (got.sum_overflow !== want.sum_overflow) begin
                $error("sum_overflow: expected %0d, got %0d",
                       want.sum_overflow, got.sum_overflow);
                errors++;
            end
            if (got.bits_for_block !== want.bits_for_block) begin
                $error("bits_for_block: expected %0d, got %0d",
                       want.bits_for_block, got.bits_for_block);
                errors++;
            end
            if (got.start_position !== want.start_position) begin
                $error("start_position: expected %0d, got %0d",
                       want.start_position, got.start_position);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmbs_in_if  in_ch();
    rmbs_out_if out_ch();
    rmbs_cfg_if cfg_ch();

    turbo_rate_match_bit_select_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    bit_select_scoreboard sb = new();

    int burst_left = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: checks each result and then picks ready from the current stall pattern.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status = out_ch.status;
            got.selected_value = out_ch.selected_value;
            got.buffer_position = out_ch.buffer_position;
            got.last_of_run = out_ch.last_of_run;
            got.sum_overflow = out_ch.sum_overflow;
            got.bits_for_block = out_ch.bits_for_block;
            got.start_position = out_ch.start_position;
            sb.check_result(got);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(40, 300);
        end
        stall_left--;
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(t_sel_item it);
        if (burst_left == 0) begin
            int gap;
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.command <= it.cmd;
        in_ch.entry_index <= it.index;
        in_ch.entry_value <= it.value;
        in_ch.entry_is_null <= it.is_null;
        in_ch.redundancy_version <= it.rv;
        in_ch.block_number <= it.block;
        in_ch.soft_sample <= it.sample;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    // Random content in every field; the caller overrides what matters.
    function automatic t_sel_item rand_item(t_cmd_code cmd);
        t_sel_item it;
        int        pick;
        it.cmd = cmd;
        pick = $urandom_range(0, 15);
        if (pick == 0) it.index = 15'($urandom_range(DEPTH, 32767));
        else if (pick < 3) it.index = 15'($urandom_range(0, DEPTH - 1));
        else it.index = 15'($urandom_range(0, FILL - 1));
        case ($urandom_range(0, 5))
            0: it.value = 16'h7FFF;
            1: it.value = 16'h8000;
            default: it.value = 16'($urandom);
        endcase
        it.is_null = ($urandom_range(0, 7) == 0);
        it.rv = 2'($urandom_range(0, 3));
        it.block = 8'($urandom_range(0, 254));
        case ($urandom_range(0, 5))
            0: it.sample = 16'h7FFF;
            1: it.sample = 16'h8000;
            default: it.sample = 16'($urandom);
        endcase
        return it;
    endfunction

    task automatic send_cmd(t_cmd_code cmd);
        send_item(rand_item(cmd));
    endtask

    task automatic send_load(int idx, logic [15:0] val, logic is_null);
        t_sel_item it;
        it = rand_item(CMD_LOAD);
        it.index = 15'(idx);
        it.value = val;
        it.is_null = is_null;
        send_item(it);
    endtask

    task automatic send_start(logic [1:0] rv, logic [7:0] blk);
        t_sel_item it;
        it = rand_item(CMD_START);
        it.rv = rv;
        it.block = blk;
        send_item(it);
    endtask

    task automatic send_combine(logic [15:0] smp);
        t_sel_item it;
        it = rand_item(CMD_COMBINE);
        it.sample = smp;
        send_item(it);
    endtask

    // Register writes happen only with the block idle: no result due and a start
    // or load given time to finish.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(int unsigned vals [8]);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr <= t_cfg_idx'(i);
            cfg_ch.data <= CFG_W'(vals[i]);
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            sb.write_reg(t_cfg_idx'(i), CFG_W'(vals[i]));
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(int count, bit hold_midway);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (hold_midway && n == count / 2) wait_drained();
            pick = $urandom_range(0, 19);
            if (pick < 2) send_cmd(CMD_START);
            else if (pick < 10) send_cmd(CMD_EMIT);
            else if (pick < 15) send_cmd(CMD_COMBINE);
            else send_cmd(CMD_LOAD);
        end
    endtask

    initial begin
        int unsigned vals [8];
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.command <= CMD_LOAD;
        in_ch.entry_index <= '0;
        in_ch.entry_value <= '0;
        in_ch.entry_is_null <= 1'b0;
        in_ch.redundancy_version <= '0;
        in_ch.block_number <= '0;
        in_ch.soft_sample <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.addr <= CFG_ROWS;
        cfg_ch.data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No run yet: emit and combine report it.
        send_cmd(CMD_EMIT);
        send_cmd(CMD_COMBINE);

        // Fill every entry a run can reach so no scan meets an entry never written.
        for (int i = 0; i < FILL; i++) begin
            t_sel_item it;
            it = rand_item(CMD_LOAD);
            it.index = 15'(i);
            send_item(it);
        end
        send_load(DEPTH, 16'h1234, 1'b0);
        send_load(32767, 16'h4321, 1'b1);

        // With the reset registers E is zero, so a start leaves no run behind.
        send_start(2'd0, 8'd0);
        send_cmd(CMD_EMIT);

        vals = '{192, 1048575, 1, 4000, 15, 2, 8, 4};
        write_regs(vals);
        for (int rv = 0; rv < 4; rv++) begin
            send_start(2'(rv), (rv == 3) ? 8'd254 : 8'd0);
            send_cmd(CMD_EMIT);
            send_combine(16'h7FFF);
            send_combine(16'h8000);
        end
        // Load during a run, then a restart in the middle of it.
        send_load(0, 16'h7FFF, 1'b0);
        send_start(2'd0, 8'd1);
        send_cmd(CMD_EMIT);

        // Only null entries inside a short circular buffer.
        vals = '{1, 100, 1, 64, 8, 1, 2, 1};
        write_regs(vals);
        for (int i = 0; i < 8; i++) send_load(i, 16'($urandom), 1'b1);
        send_start(2'd1, 8'd0);
        send_cmd(CMD_EMIT);
        send_combine(16'h0001);
        send_load(3, 16'h7FFF, 1'b0);
        send_combine(16'h0001);
        send_cmd(CMD_EMIT);

        // Nsoft of one gives an Ncb of one; zero registers elsewhere.
        vals = '{0, 5000, 0, 1, 0, 0, 0, 0};
        write_regs(vals);
        send_start(2'd2, 8'd3);
        random_phase(20, 1'b0);

        vals = '{255, 60000, 255, 300000, 3, 3, 6, 3};
        write_regs(vals);
        random_phase(60, 1'b1);

        vals = '{1, 6000, 3, 1000, 1, 1, 2, 2};
        write_regs(vals);
        random_phase(60, 1'b0);

        // Few rows bound Ncb by 96 * R_TC; otherwise a small Nsoft bounds it.
        for (int p = 0; p < 6; p++) begin
            vals[CFG_ROWS] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 2);
            vals[CFG_TOTAL] = $urandom_range(0, 1048575);
            vals[CFG_BLOCKS] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(1, 6);
            vals[CFG_NSOFT] = (vals[CFG_ROWS] inside {[0:2]}) ? $urandom_range(0, 4194303)
                                                              : $urandom_range(0, FILL);
            vals[CFG_HARQ] = $urandom_range(0, 15);
            vals[CFG_MIMO] = $urandom_range(0, 3);
            vals[CFG_QM] = $urandom_range(0, 15);
            vals[CFG_LAYERS] = $urandom_range(0, 7);
            write_regs(vals);
            random_phase(70, 1'b0);
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rmbs_pkg.sv
hdl/rmbs_if.sv
hdl/rmbs_div.sv
hdl/rmbs_ctrl.sv
hdl/rmbs_dp.sv
hdl/turbo_rate_match_bit_select_top.sv
hdl/rmbs_checker.sv
tb/sv/turbo_rate_match_bit_select_top_test.sv
